[rtl/core/assert_macros.svh]
// assertion macros used by the checker file pfd_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[rtl/core/pfd_pkg.sv]
// types and constants of the packet fifo with duplicate filter
// no dependencies
`timescale 1ns / 1ps

package pfd_pkg;

   localparam int SRC_W   = 18;
   localparam int TIME_W  = 30;
   localparam int CNT_W   = 7;
   localparam int LIMIT_W = 7;
   localparam int FUNC_W  = 2;
   localparam int GROUP_W = 8;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [CNT_W-1:0]   CNT_MAX     = 7'd127;

   localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FORWARD = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COUNT   = 2'd2;

   // word index of the limit register
   localparam logic REG_LIMIT = 1'b0;

   typedef struct packed {
      logic [SRC_W-1:0]  src;
      logic [SRC_W-1:0]  dst;
      logic [TIME_W-1:0] ts;
   } pkt_type;

   typedef struct packed {
      logic sample;   // latch compare flags
      logic shift;    // take neighbor's entry
   } cell_ctl_type;

   typedef struct packed {
      logic             done;
      logic             dup;
      logic [CNT_W-1:0] count;
   } tally_res_type;

endpackage

[rtl/core/pfd_cell.sv]
// one slot of the packet chain: holds an entry, shifts toward the head,
// compares itself against the current query; uses pfd_pkg
`timescale 1ns / 1ps

module pfd_cell import pfd_pkg::*; (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic              load,
   input  pkt_type           new_pkt,
   input  pkt_type           nbr_pkt,
   input  logic              held,
   input  pkt_type           query,
   input  logic [TIME_W-1:0] t_lo,
   input  logic [TIME_W-1:0] t_hi,
   output pkt_type           entry,
   output logic              dup,
   output logic              hit
);

   pkt_type entry_ff, entry_in;
   logic    dup_ff, dup_in;
   logic    hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = new_pkt;
      end else if (ctl.shift) begin
         entry_in = nbr_pkt;
      end
      dup_in = dup_ff;
      hit_in = hit_ff;
      if (ctl.sample) begin
         dup_in = held && (entry_ff == query);
         hit_in = held && (entry_ff.dst == query.dst) &&
                  (entry_ff.ts >= t_lo) && (entry_ff.ts <= t_hi);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      dup_ff   <= dup_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign dup   = dup_ff;
   assign hit   = hit_ff;

endmodule

[rtl/core/pfd_tally.sv]
// walks the cell flags eight at a time: or of duplicate flags and a
// saturating count of range hits; uses pfd_pkg
`timescale 1ns / 1ps

module pfd_tally import pfd_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CAPACITY-1:0] dup_vec,
   input  logic [CAPACITY-1:0] hit_vec,
   output tally_res_type       res
);

   localparam int NGRP = (CAPACITY + GROUP_W - 1) / GROUP_W;
   localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PADW = NGRP * GROUP_W;
   localparam int PW   = $clog2(PADW);

   logic [GW-1:0]      grp_ff, grp_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               dup_ff, dup_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic [PADW-1:0]    dup_pad, hit_pad;
   logic [PW-1:0]      base;
   logic [GROUP_W-1:0] hit_grp, dup_grp;
   logic [3:0]         pop;
   logic [CNT_W:0]     sum;
   logic               last;

   always_comb begin
      dup_pad = '0;
      hit_pad = '0;
      dup_pad[CAPACITY-1:0] = dup_vec;
      hit_pad[CAPACITY-1:0] = hit_vec;
      base    = PW'({grp_ff, 3'b000});
      hit_grp = hit_pad[base +: GROUP_W];
      dup_grp = dup_pad[base +: GROUP_W];
      pop = '0;
      for (int b = 0; b < GROUP_W; b++) begin
         pop = pop + 4'(hit_grp[b]);
      end
      sum  = {1'b0, acc_ff} + (CNT_W + 1)'(pop);
      last = (grp_ff == GW'(NGRP - 1));

      grp_in  = grp_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dup_in  = dup_ff;
      acc_in  = acc_ff;
      if (start) begin
         grp_in  = '0;
         busy_in = 1'b1;
         dup_in  = 1'b0;
         acc_in  = '0;
      end else if (busy_ff) begin
         dup_in = dup_ff | (|dup_grp);
         // count saturates at the top of the result field
         acc_in = (sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            grp_in = grp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      grp_ff <= grp_in;
      dup_ff <= dup_in;
      acc_ff <= acc_in;
   end

   assign res.done  = done_ff;
   assign res.dup   = dup_ff;
   assign res.count = acc_ff;

endmodule

[rtl/core/packet_fifo_dedup_range_count.sv]
// top level of the bounded packet fifo with duplicate filter and range count
// uses pfd_pkg, pfd_cell, pfd_tally
`timescale 1ns / 1ps

// Packets sit in a row of CAPACITY cells, oldest in cell 0; forward and an
// evicting add shift the whole row one cell toward the head. One item is in
// work at a time. Forward and unknown operations go from acceptance straight
// to the update step, which registers their result beat. Add and count first
// let every cell compare itself against the request in the compare step, then
// the flag tally walks the cells eight per cycle, and the update step then
// registers their result beat. A new request is taken only once the last item
// has left the update step. The result sits in an output register; a new
// request can be taken while it waits, and a stalled result holds the next
// one in its last step. memory_limit (byte address 0) of 0 acts as 1 and
// above CAPACITY acts as CAPACITY; write it only while the block is idle.
module packet_fifo_dedup_range_count import pfd_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [SRC_W-1:0]   req_source,
   input  logic [SRC_W-1:0]   req_destination,
   input  logic [TIME_W-1:0]  req_timestamp,
   input  logic [TIME_W-1:0]  req_start_time,
   input  logic [TIME_W-1:0]  req_end_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [SRC_W-1:0]   rsp_out_source,
   output logic [SRC_W-1:0]   rsp_out_destination,
   output logic [TIME_W-1:0]  rsp_out_timestamp,
   output logic [CNT_W-1:0]   rsp_match_count,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int OW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = (OW > LIMIT_W) ? OW : LIMIT_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   pkt_type            query_ff, query_in;
   logic [TIME_W-1:0]  tlo_ff, tlo_in;
   logic [TIME_W-1:0]  thi_ff, thi_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               ok_ff, ok_in;
   pkt_type            out_ff, out_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               req_accept;
   logic               csr_write;
   logic               can_emit;
   logic [CW-1:0]      lim_eff;
   logic               full;
   logic               do_load;
   logic [IW-1:0]      widx;
   cell_ctl_type       ctl;
   tally_res_type      tres;

   pkt_type            entry_w [CAPACITY];
   logic [CAPACITY-1:0] held_w, load_w, dup_w, hit_w;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LIMIT) ? CSR_DW'(limit_ff) : '0;
   assign can_emit   = !rsp_valid_ff || !rsp_stall;

   // clamp the configured limit into 1..CAPACITY
   always_comb begin
      lim_eff = CW'(limit_ff);
      if (limit_ff == '0) begin
         lim_eff = CW'(1);
      end else if (CW'(limit_ff) > CW'(CAPACITY)) begin
         lim_eff = CW'(CAPACITY);
      end
   end

   assign full = (CW'(occ_ff) >= lim_eff);

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      occ_in       = occ_ff;
      func_in      = func_ff;
      query_in     = query_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ok_in        = ok_ff;
      out_in       = out_ff;
      cnt_in       = cnt_ff;
      ctl          = '0;
      do_load      = 1'b0;
      widx         = IW'(occ_ff);

      if (csr_write && (csr_paddr[2] == REG_LIMIT)) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in      = req_func;
               query_in.src = req_source;
               query_in.dst = req_destination;
               query_in.ts  = req_timestamp;
               tlo_in       = req_start_time;
               thi_in       = req_end_time;
               state_in     = ((req_func == FUNC_ADD) || (req_func == FUNC_COUNT)) ?
                              ST_CMP : ST_UPD;
            end
         end
         ST_CMP: begin
            ctl.sample = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            if (tres.done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               ok_in        = 1'b0;
               out_in       = '0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
               if (func_ff == FUNC_ADD) begin
                  if (!tres.dup) begin
                     ok_in   = 1'b1;
                     do_load = 1'b1;
                     if (full) begin
                        // evict the oldest and append behind the rest
                        ctl.shift = 1'b1;
                        widx      = IW'(occ_ff - OW'(1));
                     end else begin
                        occ_in = occ_ff + OW'(1);
                     end
                  end
               end else if (func_ff == FUNC_FORWARD) begin
                  if (occ_ff != '0) begin
                     ok_in     = 1'b1;
                     out_in    = entry_w[0];
                     ctl.shift = 1'b1;
                     occ_in    = occ_ff - OW'(1);
                  end
               end else if (func_ff == FUNC_COUNT) begin
                  cnt_in = tres.count;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff  <= func_in;
      query_ff <= query_in;
      tlo_ff   <= tlo_in;
      thi_ff   <= thi_in;
      ok_ff    <= ok_in;
      out_ff   <= out_in;
      cnt_ff   <= cnt_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign held_w[i] = (OW'(i) < occ_ff);
      assign load_w[i] = do_load && (widx == IW'(i));

      if (i == CAPACITY - 1) begin : g_tail
         pfd_cell u_cell (
            .clock   (clock),
            .ctl     (ctl),
            .load    (load_w[i]),
            .new_pkt (query_ff),
            .nbr_pkt (entry_w[i]),
            .held    (held_w[i]),
            .query   (query_ff),
            .t_lo    (tlo_ff),
            .t_hi    (thi_ff),
            .entry   (entry_w[i]),
            .dup     (dup_w[i]),
            .hit     (hit_w[i])
         );
      end else begin : g_body
         pfd_cell u_cell (
            .clock   (clock),
            .ctl     (ctl),
            .load    (load_w[i]),
            .new_pkt (query_ff),
            .nbr_pkt (entry_w[i+1]),
            .held    (held_w[i]),
            .query   (query_ff),
            .t_lo    (tlo_ff),
            .t_hi    (thi_ff),
            .entry   (entry_w[i]),
            .dup     (dup_w[i]),
            .hit     (hit_w[i])
         );
      end
   end

   pfd_tally #(.CAPACITY(CAPACITY)) u_tally (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.sample),
      .dup_vec (dup_w),
      .hit_vec (hit_w),
      .res     (tres)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = ok_ff;
   assign rsp_out_source      = out_ff.src;
   assign rsp_out_destination = out_ff.dst;
   assign rsp_out_timestamp   = out_ff.ts;
   assign rsp_match_count     = cnt_ff;

endmodule

[rtl/core/pfd_checker.sv]
// port-level checks on the packet fifo result channel, bound to the top level
// uses pfd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfd_checker import pfd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_ok,
   input logic [SRC_W-1:0]  rsp_out_source,
   input logic [SRC_W-1:0]  rsp_out_destination,
   input logic [TIME_W-1:0] rsp_out_timestamp,
   input logic [CNT_W-1:0]  rsp_match_count
);

   logic pkt_zero;

   assign pkt_zero = (rsp_out_source == '0) && (rsp_out_destination == '0) &&
                     (rsp_out_timestamp == '0);

   // no beat is offered in the cycle after reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   // a stalled beat stays offered
   `ASSERT_NEXT(a_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // an ok beat is an add or a forward, never a count
   `ASSERT_IMP(a_ok_no_count, clock, reset, rsp_valid && rsp_ok, rsp_match_count == '0)

   // packet fields only travel with a successful forward
   `ASSERT_IMP(a_pkt_needs_ok, clock, reset, rsp_valid && !rsp_ok, pkt_zero)

endmodule

bind packet_fifo_dedup_range_count pfd_checker u_pfd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_ok              (rsp_ok),
   .rsp_out_source      (rsp_out_source),
   .rsp_out_destination (rsp_out_destination),
   .rsp_out_timestamp   (rsp_out_timestamp),
   .rsp_match_count     (rsp_match_count)
);
